>>> sv/lpm_pkg.sv
package lpm_pkg;

    localparam int unsigned ADDR_W = 32;
    localparam int unsigned PLEN_W = 6;
    localparam int unsigned PORT_W = 3;
    localparam logic [PLEN_W-1:0] PLEN_MAX = PLEN_W'(32);

    typedef enum logic
    {
        OP_APPEND = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    typedef enum logic
    {
        ST_OK   = 1'b0,
        ST_FULL = 1'b1
    } status_t;

    typedef enum logic
    {
        BK_IDLE,
        BK_WALK
    } back_state_t;

    typedef struct packed
    {
        logic [ADDR_W-1:0] net;
        logic [PLEN_W-1:0] plen;
        logic [PORT_W-1:0] port;
    } route_t;

    typedef struct packed
    {
        op_t               op;
        logic [ADDR_W-1:0] address;
        logic [PLEN_W-1:0] plen;
        logic [PORT_W-1:0] port;
    } item_t;

    // handshake between the front queue and the back engine
    typedef struct packed
    {
        logic  valid;
        item_t item;
    } queue_head_t;

    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
        logic [ADDR_W-1:0] m;
        begin
            if (plen == '0)
            begin
                m = '0;
            end
            else
            begin
                m = {ADDR_W{1'b1}} << (PLEN_W'(ADDR_W) - plen);
            end
            return m;
        end
    endfunction

endpackage

>>> sv/lpm_ram.sv
module lpm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/lpm_front.sv
module lpm_front
    import lpm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid,
    output logic                ready,
    input  logic                cmd,
    input  logic [ADDR_W-1:0]   address,
    input  logic [PLEN_W-1:0]   prefix_len,
    input  logic [PORT_W-1:0]   port,
    output queue_head_t         head,
    input  logic                pop
);

    // two-entry queue decouples intake from the search engine
    item_t      slot_reg [2];
    item_t      slot_next [2];
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    item_t      in_item;
    logic       push;

    always_comb
    begin
        in_item.op      = op_t'(cmd);
        in_item.address = address;
        in_item.plen    = (prefix_len > PLEN_MAX) ? PLEN_MAX : prefix_len;
        in_item.port    = port;
    end

    assign ready = (fill_reg != 2'd2);
    assign push  = valid && ready;

    always_comb
    begin
        slot_next[0] = slot_reg[0];
        slot_next[1] = slot_reg[1];
        fill_next    = fill_reg;
        if (pop)
        begin
            slot_next[0] = slot_reg[1];
            fill_next    = fill_next - 2'd1;
        end
        if (push)
        begin
            if ((pop ? fill_reg - 2'd1 : fill_reg) == 2'd0)
            begin
                slot_next[0] = in_item;
            end
            else
            begin
                slot_next[1] = in_item;
            end
            fill_next = fill_next + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 2'd0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
    end

    assign head.valid = (fill_reg != 2'd0);
    assign head.item  = slot_reg[0];

endmodule

>>> sv/lpm_engine.sv
module lpm_engine
    import lpm_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  queue_head_t         head,
    output logic                pop,
    output logic                ram_we,
    output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] ram_waddr,
    output route_t              ram_wdata,
    output logic                ram_re,
    output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] ram_raddr,
    input  route_t              ram_rdata,
    output logic                res_valid,
    input  logic                res_ready,
    output logic                hit,
    output logic [PORT_W-1:0]   out_port,
    output logic                status
);

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    back_state_t       state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic              found_reg, found_next;
    logic [PLEN_W-1:0] best_len_reg, best_len_next;
    logic [PORT_W-1:0] best_port_reg, best_port_next;
    logic [ADDR_W-1:0] dst_reg, dst_next;
    logic              res_valid_reg, res_valid_next;
    logic              hit_reg, hit_next;
    logic [PORT_W-1:0] port_reg, port_next;
    status_t           status_reg, status_next;

    logic              start;
    logic              walk_end;
    logic              match;
    logic [ADDR_W-1:0] m;

    assign start = (state_reg == BK_IDLE) && head.valid && (!res_valid_reg || res_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (start && head.item.op == OP_LOOKUP)
                begin
                    state_next = BK_WALK;
                end
            end
            BK_WALK:
            begin
                if (walk_end)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        walk_end  = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                pop    = start;
                ram_we = start && (head.item.op == OP_APPEND) && (count_reg < DEPTH_C);
            end
            BK_WALK:
            begin
                ram_re   = (idx_reg < count_reg);
                walk_end = (idx_reg >= count_reg) && !pend_reg;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    assign ram_waddr = count_reg[AW-1:0];
    assign ram_raddr = idx_reg[AW-1:0];
    always_comb
    begin
        ram_wdata.net  = head.item.address;
        ram_wdata.plen = head.item.plen;
        ram_wdata.port = head.item.port;
    end

    // entry read last cycle is checked against the held destination
    assign m     = prefix_mask(ram_rdata.plen);
    assign match = ((dst_reg & m) == (ram_rdata.net & m));

    always_comb
    begin
        count_next     = count_reg;
        idx_next       = idx_reg;
        pend_next      = ram_re;
        found_next     = found_reg;
        best_len_next  = best_len_reg;
        best_port_next = best_port_reg;
        dst_next       = dst_reg;
        res_valid_next = res_valid_reg && !res_ready;
        hit_next       = hit_reg;
        port_next      = port_reg;
        status_next    = status_reg;

        if (ram_we)
        begin
            count_next = count_reg + CW'(1);
        end
        if (ram_re)
        begin
            idx_next = idx_reg + CW'(1);
        end

        if (start)
        begin
            if (head.item.op == OP_APPEND)
            begin
                res_valid_next = 1'b1;
                hit_next       = 1'b0;
                port_next      = '0;
                status_next    = (count_reg < DEPTH_C) ? ST_OK : ST_FULL;
            end
            else
            begin
                idx_next       = '0;
                found_next     = 1'b0;
                best_len_next  = '0;
                best_port_next = '0;
                dst_next       = head.item.address;
            end
        end

        if (pend_reg && match && (!found_reg || ram_rdata.plen > best_len_reg))
        begin
            found_next     = 1'b1;
            best_len_next  = ram_rdata.plen;
            best_port_next = ram_rdata.port;
        end

        if (walk_end)
        begin
            res_valid_next = 1'b1;
            hit_next       = found_reg;
            port_next      = best_port_reg;
            status_next    = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        found_reg     <= found_next;
        best_len_reg  <= best_len_next;
        best_port_reg <= best_port_next;
        dst_reg       <= dst_next;
        hit_reg       <= hit_next;
        port_reg      <= port_next;
        status_reg    <= status_next;
    end

    assign res_valid = res_valid_reg;
    assign hit       = hit_reg;
    assign out_port  = port_reg;
    assign status    = status_reg;

endmodule

>>> sv/longest_prefix_match_table_top.sv
// IPv4 longest-prefix-match route table, searched one entry per cycle.
// Input channel (in_valid/in_ready): cmd 0 appends a route (address,
// prefix_len saturated to 32, port); cmd 1 looks up destination address.
// Output channel (out_valid/out_ready): one result item per input item, in
// order: hit, out_port, status (1 = append refused, table full).
// Items pass through a two-entry input queue, so intake carries on while the
// search engine is busy or a result waits to be taken.
// An append's result is registered when the engine takes the item from the
// queue; a lookup's result waits until the engine has walked every stored
// entry through the single read port of the route RAM, one stored entry per
// cycle, up to TABLE_DEPTH entries. One item is searched at a time.
// Reset clears the entry count, queue and result register; route RAM
// contents need no clearing as only stored entries are read.
// A stalled receiver holds the result; the engine waits and the input queue
// fills, after which in_ready drops.
module longest_prefix_match_table_top
    import lpm_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                cmd,
    input  logic [ADDR_W-1:0]   address,
    input  logic [PLEN_W-1:0]   prefix_len,
    input  logic [PORT_W-1:0]   port,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                hit,
    output logic [PORT_W-1:0]   out_port,
    output logic                status
);

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    queue_head_t   head;
    logic          pop;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    route_t        ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    route_t        ram_rdata;

    lpm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (in_valid),
        .ready      (in_ready),
        .cmd        (cmd),
        .address    (address),
        .prefix_len (prefix_len),
        .port       (port),
        .head       (head),
        .pop        (pop)
    );

    lpm_ram #(
        .WIDTH ($bits(route_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_route_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lpm_engine #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .res_valid (out_valid),
        .res_ready (out_ready),
        .hit       (hit),
        .out_port  (out_port),
        .status    (status)
    );

endmodule
